// ===== design/tcbhs_pkg.sv =====
// Shared types, constants and helpers for the two-choice bucket hash set.
`timescale 1ns / 1ps

package tcbhs_pkg;

   localparam int SLOTS_PER_BUCKET = 8;
   localparam int BUCKETS_PER_HALF = 64;

   localparam int ROWS         = 2 * BUCKETS_PER_HALF;
   localparam int TOTAL_SLOTS  = ROWS * SLOTS_PER_BUCKET;
   localparam int BUCKET_W     = (BUCKETS_PER_HALF > 1) ? $clog2(BUCKETS_PER_HALF) : 1;
   localparam int ROW_W        = $clog2(ROWS);
   localparam int SLOT_W       = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
   localparam int CNT_W        = $clog2(SLOTS_PER_BUCKET + 1);
   localparam int TOTAL_W      = $clog2(TOTAL_SLOTS + 1);
   localparam int KEY_W        = 64;
   localparam int SLOT_INDEX_W = 11;

   localparam logic [31:0] MULT_FIRST  = 32'ha96347c5;
   localparam logic [31:0] MULT_SECOND = 32'he65ac2d3;
   localparam logic [31:0] BUCKET_MASK = 32'(BUCKETS_PER_HALF - 1);

   // Operation codes; the unused code behaves as a lookup.
   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   // Status codes.
   localparam logic [1:0] ST_FOUND    = 2'd0;
   localparam logic [1:0] ST_INSERTED = 2'd1;
   localparam logic [1:0] ST_MISSING  = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic [1:0]              op;
      logic signed [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [SLOT_INDEX_W-1:0] slot_index;
      logic [1:0]              status;
   } rsp_type;

   // One bucket: valid bits and keys of all its slots.
   typedef struct packed {
      logic [SLOTS_PER_BUCKET-1:0]            valid;
      logic [SLOTS_PER_BUCKET-1:0][KEY_W-1:0] keys;
   } row_type;

   // Item after hashing, as it moves through the pipeline.
   typedef struct packed {
      logic [1:0]       op;
      logic [KEY_W-1:0] key;
      logic [ROW_W-1:0] row0;
      logic [ROW_W-1:0] row1;
   } stage_type;

   // Row write-back command.
   typedef struct packed {
      logic             we;
      logic [ROW_W-1:0] addr;
      row_type          row;
   } wr_type;

   // One-based slot number of a slot within a row, cut to the output width.
   function automatic logic [SLOT_INDEX_W-1:0] slot_number(input logic [ROW_W-1:0] row,
                                                            input logic [SLOT_W-1:0] s);
      logic [TOTAL_W-1:0] n;
      n = TOTAL_W'(row) * TOTAL_W'(SLOTS_PER_BUCKET) + TOTAL_W'(s) + TOTAL_W'(1);
      return SLOT_INDEX_W'(n);
   endfunction

endpackage

// ===== design/tcbhs_hash.sv =====
// Key folding and the two multiplicative hashes that pick one bucket row per half.
`timescale 1ns / 1ps

module tcbhs_hash (
   input  logic [tcbhs_pkg::KEY_W-1:0] key,
   output logic [tcbhs_pkg::ROW_W-1:0] row0,
   output logic [tcbhs_pkg::ROW_W-1:0] row1
);
   import tcbhs_pkg::*;

   logic [31:0]         fold_lo;
   logic [31:0]         fold_hi;
   logic [31:0]         folded;
   logic [63:0]         prod0;
   logic [63:0]         prod1;
   logic [31:0]         sel0;
   logic [31:0]         sel1;
   logic [BUCKET_W-1:0] bucket0;
   logic [BUCKET_W-1:0] bucket1;

   assign fold_lo = {key[47:32], key[15:0]};
   assign fold_hi = {key[31:16], key[63:48]};
   assign folded  = fold_lo ^ fold_hi;

   assign prod0 = {32'd0, folded} * {32'd0, MULT_FIRST};
   assign prod1 = {32'd0, folded} * {32'd0, MULT_SECOND};

   assign sel0 = prod0[47:16] & BUCKET_MASK;
   assign sel1 = prod1[47:16] & BUCKET_MASK;

   assign bucket0 = BUCKET_W'(sel0);
   assign bucket1 = BUCKET_W'(sel1);

   // Second half rows sit after all first half rows.
   assign row0 = ROW_W'(bucket0);
   assign row1 = ROW_W'(bucket1) + ROW_W'(BUCKETS_PER_HALF);

endmodule

// ===== design/tcbhs_row_mem.sv =====
// Bucket row memory: two registered read ports, one write port, per-row written flags.
`timescale 1ns / 1ps

module tcbhs_row_mem (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [tcbhs_pkg::ROW_W-1:0]  rd_addr0,
   input  logic [tcbhs_pkg::ROW_W-1:0]  rd_addr1,
   output tcbhs_pkg::row_type           rd_row0,
   output tcbhs_pkg::row_type           rd_row1,
   input  tcbhs_pkg::wr_type            wr
);
   import tcbhs_pkg::*;

   row_type         row_mem [ROWS];
   logic [ROWS-1:0] written_ff;
   row_type         rd_data0_ff;
   row_type         rd_data1_ff;
   logic            rd_written0_ff;
   logic            rd_written1_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         row_mem[wr.addr] <= wr.row;
      end
      if (rd_en) begin
         rd_data0_ff    <= row_mem[rd_addr0];
         rd_data1_ff    <= row_mem[rd_addr1];
         rd_written0_ff <= written_ff[rd_addr0];
         rd_written1_ff <= written_ff[rd_addr1];
      end
   end

   // A row never written reads as all slots empty.
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr.we) begin
         written_ff[wr.addr] <= 1'b1;
      end
   end

   always_comb begin
      rd_row0       = rd_data0_ff;
      rd_row1       = rd_data1_ff;
      rd_row0.valid = rd_written0_ff ? rd_data0_ff.valid : '0;
      rd_row1.valid = rd_written1_ff ? rd_data1_ff.valid : '0;
   end

endmodule

// ===== design/tcbhs_resolve.sv =====
// Slot compare, free-slot choice and row update for one item against its two bucket rows.
`timescale 1ns / 1ps

module tcbhs_resolve (
   input  tcbhs_pkg::stage_type item,
   input  tcbhs_pkg::row_type   data0,
   input  tcbhs_pkg::row_type   data1,
   output tcbhs_pkg::rsp_type   rsp,
   output tcbhs_pkg::wr_type    wr
);
   import tcbhs_pkg::*;

   logic [SLOTS_PER_BUCKET-1:0] match0;
   logic [SLOTS_PER_BUCKET-1:0] match1;
   logic                        hit0;
   logic                        hit1;
   logic [SLOT_W-1:0]           hit0_slot;
   logic [SLOT_W-1:0]           hit1_slot;
   logic [CNT_W-1:0]            free0;
   logic [CNT_W-1:0]            free1;
   logic [SLOT_W-1:0]           last0;
   logic [SLOT_W-1:0]           last1;
   logic [ROW_W-1:0]            hit_row;
   logic [SLOT_W-1:0]           hit_slot;
   row_type                     hit_data;
   logic [ROW_W-1:0]            ins_row;
   logic [SLOT_W-1:0]           ins_slot;
   row_type                     ins_data;
   logic                        full;

   always_comb begin
      for (int i = 0; i < SLOTS_PER_BUCKET; i++) begin
         match0[i] = data0.valid[i] && (data0.keys[i] == item.key);
         match1[i] = data1.valid[i] && (data1.keys[i] == item.key);
      end
   end

   // Lowest matching slot wins; the last free slot is the highest empty one.
   always_comb begin
      hit0      = 1'b0;
      hit1      = 1'b0;
      hit0_slot = '0;
      hit1_slot = '0;
      free0     = '0;
      free1     = '0;
      last0     = '0;
      last1     = '0;
      for (int i = 0; i < SLOTS_PER_BUCKET; i++) begin
         if (!hit0 && match0[i]) begin
            hit0      = 1'b1;
            hit0_slot = SLOT_W'(i);
         end
         if (!hit1 && match1[i]) begin
            hit1      = 1'b1;
            hit1_slot = SLOT_W'(i);
         end
         if (!data0.valid[i]) begin
            free0 = free0 + CNT_W'(1);
            last0 = SLOT_W'(i);
         end
         if (!data1.valid[i]) begin
            free1 = free1 + CNT_W'(1);
            last1 = SLOT_W'(i);
         end
      end
   end

   assign hit_row  = hit0 ? item.row0 : item.row1;
   assign hit_slot = hit0 ? hit0_slot : hit1_slot;
   assign hit_data = hit0 ? data0 : data1;

   // Tie on free count goes to the first half.
   assign ins_row  = (free0 >= free1) ? item.row0 : item.row1;
   assign ins_slot = (free0 >= free1) ? last0 : last1;
   assign ins_data = (free0 >= free1) ? data0 : data1;
   assign full     = (free0 == '0) && (free1 == '0);

   always_comb begin
      rsp.slot_index = '0;
      rsp.status     = ST_MISSING;
      wr.we          = 1'b0;
      wr.addr        = hit_row;
      wr.row         = hit_data;
      priority if (hit0 || hit1) begin
         rsp.slot_index = slot_number(hit_row, hit_slot);
         rsp.status     = ST_FOUND;
         if (item.op == OP_REMOVE) begin
            wr.we                  = 1'b1;
            wr.row.valid[hit_slot] = 1'b0;
         end
      end else if (item.op == OP_INSERT) begin
         if (full) begin
            rsp.status = ST_FULL;
         end else begin
            rsp.slot_index         = slot_number(ins_row, ins_slot);
            rsp.status             = ST_INSERTED;
            wr.we                  = 1'b1;
            wr.addr                = ins_row;
            wr.row                 = ins_data;
            wr.row.keys[ins_slot]  = item.key;
            wr.row.valid[ins_slot] = 1'b1;
         end
      end else begin
         rsp.status = ST_MISSING;
      end
   end

endmodule

// ===== design/two_choice_bucket_hash_set.sv =====
// Top level of the two-choice bucket hash set: hash stage, row read, resolve and write-back.
// The request is registered in S1, S2 holds the item and both bucket rows it read, and
// the response is registered when the output is free. S1 can take a new item while S2 is busy;
// the next read waits until the previous item's row write-back has gone into the row memory.
// Reset clears all slot valid bits at once (per-row written flags); no clearing pass.
`timescale 1ns / 1ps

module two_choice_bucket_hash_set (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  tcbhs_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output tcbhs_pkg::rsp_type rsp_data
);
   import tcbhs_pkg::*;

   logic             s1_valid_ff;
   logic             s1_valid_in;
   stage_type        s1_ff;
   stage_type        s1_in;
   logic             s2_valid_ff;
   logic             s2_valid_in;
   stage_type        s2_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_ff;
   logic [ROW_W-1:0] hash_row0;
   logic [ROW_W-1:0] hash_row1;
   logic             req_take;
   logic             s1_go;
   logic             s2_done;
   row_type          row0;
   row_type          row1;
   rsp_type          res_rsp;
   wr_type           res_wr;
   wr_type           mem_wr;

   tcbhs_hash u_hash (
      .key  (req_data.key),
      .row0 (hash_row0),
      .row1 (hash_row1)
   );

   // S1 only moves on once S2 is empty, so a read never races a write to the same row.
   assign s1_go     = s1_valid_ff && !s2_valid_ff;
   assign s2_done   = s2_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_go;
   assign req_take  = req_valid && !req_stall;

   assign s1_in.op   = req_data.op;
   assign s1_in.key  = req_data.key;
   assign s1_in.row0 = hash_row0;
   assign s1_in.row1 = hash_row1;

   assign s1_valid_in  = req_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
   assign s2_valid_in  = s1_go ? 1'b1 : (s2_done ? 1'b0 : s2_valid_ff);
   assign rsp_valid_in = s2_done ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   tcbhs_row_mem u_row_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (s1_go),
      .rd_addr0 (s1_ff.row0),
      .rd_addr1 (s1_ff.row1),
      .rd_row0  (row0),
      .rd_row1  (row1),
      .wr       (mem_wr)
   );

   tcbhs_resolve u_resolve (
      .item  (s2_ff),
      .data0 (row0),
      .data1 (row1),
      .rsp   (res_rsp),
      .wr    (res_wr)
   );

   always_comb begin
      mem_wr    = res_wr;
      mem_wr.we = res_wr.we && s2_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ff <= s1_in;
      end
      if (s1_go) begin
         s2_ff <= s1_ff;
      end
      if (s2_done) begin
         rsp_ff <= res_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== design/tcbhs_checker.sv =====
// Port-level checks for the two-choice bucket hash set, bound to the top level.
`timescale 1ns / 1ps

module tcbhs_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input tcbhs_pkg::req_type req_data,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input tcbhs_pkg::rsp_type rsp_data
);
   import tcbhs_pkg::*;

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("request changed while stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_hit_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_FOUND || rsp_data.status == ST_INSERTED)
      |-> rsp_data.slot_index != '0
          && rsp_data.slot_index <= SLOT_INDEX_W'(TOTAL_SLOTS))
      else $error("hit response with slot index out of range");

   a_miss_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_MISSING || rsp_data.status == ST_FULL)
      |-> rsp_data.slot_index == '0)
      else $error("miss or full response with nonzero slot index");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind two_choice_bucket_hash_set tcbhs_checker u_tcbhs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
